[hw/rtl/bmp_pkg.sv]
package bmp_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int COORD_BITS      = 16;
  localparam logic [15:0] COORD_MASK = 16'((17'd1 << COORD_BITS) - 17'd1);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    DEPTH_1  = 2'd0,
    DEPTH_4  = 2'd1,
    DEPTH_8  = 2'd2,
    DEPTH_24 = 2'd3
  } depth_t;

  typedef enum logic {
    KIND_PIXEL   = 1'b0,
    KIND_PALETTE = 1'b1
  } kind_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DEPTH  = 2'd2;

  // one accepted data byte waiting to be expanded into pixels
  typedef struct packed {
    depth_t      depth;
    logic [7:0]  bits;      // remaining packed indexes, MSB first
    logic [3:0]  remain;    // pixels still to issue, 1..8
    logic [15:0] x;
    logic [15:0] y;
    logic [23:0] rgb;       // direct color for 24-bit depth: r,g,b
    logic        img_last;  // last pixel of this byte ends the image
  } job_t;

endpackage

[hw/rtl/bmp_pixel_row_unpacker.sv]
// Channel   Dir  Word                                         Side band
// s_axis    in   tdata: byte, pal index, pal r, pal g, pal b  tuser: kind
// m_axis    out  tdata: x, y, red, green, blue                tuser: last of byte,
//                                                             tlast: last of image
// cfg       in   cfg_wdata to register cfg_index              -
//
// One pixel leaves per cycle while the consumer is ready; a data byte yields
// from 0 to 8 pixels, and one that yields none issues no lookup.
// The single palette read port sets that figure: one lookup per pixel.
// A new byte is taken while the previous one issues its last lookup, and the
// output register holds a pixel for a stalled consumer; no lookup issues then.
// rst is synchronous; it clears position and control state, the palette
// holds garbage until written.
module bmp_pixel_row_unpacker import bmp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] data_byte, [15:8] palette_index, [23:16] palette_red,
  // [31:24] palette_green, [39:32] palette_blue
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] pixel_x, [31:16] pixel_y, [39:32] red, [47:40] green, [55:48] blue
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] last_of_item
  output logic [0:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata
);

  logic [23:0] palette [PALETTE_ENTRIES];
  logic [23:0] pal_rdata;

  logic [15:0] image_width;
  logic [15:0] image_height;
  depth_t      pixel_depth;
  logic [15:0] column_count;
  logic [15:0] rows_done;
  logic [1:0]  row_byte_phase;
  logic [1:0]  rgb_phase;
  logic [7:0]  held_blue;
  logic [7:0]  held_green;
  logic        image_done;

  job_t        job;
  logic        job_valid;

  logic        out_valid;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [23:0] out_rgb;
  logic        out_use_pal;
  logic        out_oob;
  logic        out_last_item;
  logic        out_last_img;

  kind_t       in_kind;
  logic [7:0]  in_byte;
  logic [7:0]  in_pal_index;
  logic [23:0] in_pal_rgb;
  logic        in_acc;
  logic        pix_acc;

  logic        issue;
  logic [7:0]  rd_index;
  logic        rd_oob;

  logic        col_lt_w;
  logic [15:0] span;
  logic [3:0]  n_pix;
  logic [15:0] col_new;
  logic [1:0]  phase_new;
  logic [15:0] rows_inc;
  logic        row_end;
  job_t        job_new;

  assign in_kind      = kind_t'(s_axis_tuser[0]);
  assign in_byte      = s_axis_tdata[7:0];
  assign in_pal_index = s_axis_tdata[15:8];
  assign in_pal_rgb   = {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};

  assign issue         = job_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !job_valid || (issue && job.remain == 4'd1);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pix_acc       = in_acc && in_kind == KIND_PIXEL && !image_done;

  // pixel count and position update for the byte at the input
  always_comb begin
    col_lt_w  = column_count < image_width;
    span      = image_width - column_count;
    n_pix     = 4'd0;
    if (col_lt_w) begin
      unique case (pixel_depth)
        DEPTH_1:  n_pix = (span >= 16'd8) ? 4'd8 : span[3:0];
        DEPTH_4:  n_pix = (span >= 16'd2) ? 4'd2 : span[3:0];
        DEPTH_8:  n_pix = 4'd1;
        DEPTH_24: n_pix = (rgb_phase == 2'd2) ? 4'd1 : 4'd0;
        default:  n_pix = 4'd0;
      endcase
    end
    col_new   = column_count + {12'd0, n_pix};
    phase_new = row_byte_phase + 2'd1;
    row_end   = (col_new >= image_width) && (phase_new == 2'd0);
    rows_inc  = rows_done + 16'd1;

    job_new.depth    = pixel_depth;
    job_new.bits     = in_byte;
    job_new.remain   = n_pix;
    job_new.x        = column_count;
    job_new.y        = (image_height - 16'd1 - rows_done) & COORD_MASK;
    job_new.rgb      = {in_byte, held_green, held_blue};
    job_new.img_last = (({1'b0, rows_done} + 17'd1) >= {1'b0, image_height})
                       && (col_new == image_width);
  end

  // palette index of the pixel being issued
  always_comb begin
    unique case (job.depth)
      DEPTH_1:  rd_index = {7'd0, job.bits[7]};
      DEPTH_4:  rd_index = {4'd0, job.bits[7:4]};
      DEPTH_8:  rd_index = job.bits;
      DEPTH_24: rd_index = 8'd0;
      default:  rd_index = 8'd0;
    endcase
    rd_oob = {1'b0, rd_index} >= 9'(PALETTE_ENTRIES);
  end

  // palette memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && in_kind == KIND_PALETTE && {1'b0, in_pal_index} < 9'(PALETTE_ENTRIES)) begin
      palette[in_pal_index[PAL_AW-1:0]] <= in_pal_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pal_rdata <= palette[rd_index[PAL_AW-1:0]];
    end
  end

  // configuration and stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 16'd1;
      image_height   <= 16'd1;
      pixel_depth    <= DEPTH_24;
      column_count   <= 16'd0;
      rows_done      <= 16'd0;
      row_byte_phase <= 2'd0;
      rgb_phase      <= 2'd0;
      held_blue      <= 8'd0;
      held_green     <= 8'd0;
      image_done     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WIDTH:  image_width  <= cfg_wdata & COORD_MASK;
          REG_HEIGHT: image_height <= cfg_wdata & COORD_MASK;
          REG_DEPTH:  pixel_depth  <= depth_t'(cfg_wdata[1:0]);
          default: ;
        endcase
      end
      if (pix_acc) begin
        row_byte_phase <= phase_new;
        if (row_end) begin
          column_count <= 16'd0;
          rows_done    <= rows_inc;
          if (rows_inc >= image_height) begin
            image_done <= 1'b1;
          end
        end else begin
          column_count <= col_new;
        end
        if (row_end) begin
          rgb_phase <= 2'd0;
        end else if (col_lt_w && pixel_depth == DEPTH_24) begin
          if (rgb_phase == 2'd0) begin
            rgb_phase <= 2'd1;
          end else if (rgb_phase == 2'd1) begin
            rgb_phase <= 2'd2;
          end else begin
            rgb_phase <= 2'd0;
          end
        end
        if (col_lt_w && pixel_depth == DEPTH_24) begin
          if (rgb_phase == 2'd0) begin
            held_blue <= in_byte;
          end else if (rgb_phase == 2'd1) begin
            held_green <= in_byte;
          end
        end
      end
    end
  end

  // pending byte: issues one palette lookup per cycle while the output register is empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (pix_acc && n_pix != 4'd0) begin
      job_valid <= 1'b1;
    end else if (issue && job.remain == 4'd1) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc && n_pix != 4'd0) begin
      job <= job_new;
    end else if (issue) begin
      job.remain <= job.remain - 4'd1;
      job.x      <= job.x + 16'd1;
      if (job.depth == DEPTH_4) begin
        job.bits <= {job.bits[3:0], 4'd0};
      end else begin
        job.bits <= {job.bits[6:0], 1'b0};
      end
    end
  end

  // output register; palette data joins it from the memory read register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_x         <= job.x & COORD_MASK;
      out_y         <= job.y;
      out_rgb       <= job.rgb;
      out_use_pal   <= job.depth != DEPTH_24;
      out_oob       <= rd_oob;
      out_last_item <= job.remain == 4'd1;
      out_last_img  <= job.remain == 4'd1 && job.img_last;
    end
  end

  logic [23:0] pix_rgb;

  always_comb begin
    if (!out_use_pal) begin
      pix_rgb = out_rgb;
    end else if (out_oob) begin
      pix_rgb = 24'd0;
    end else begin
      pix_rgb = pal_rdata;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {pix_rgb[7:0], pix_rgb[15:8], pix_rgb[23:16], out_y, out_x};
  assign m_axis_tuser  = out_last_item;
  assign m_axis_tlast  = out_last_img;

endmodule

[hw/rtl/bmp_checker.sv]
module bmp_checker import bmp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [0:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser,
  input logic                  m_axis_tlast,
  input logic                  cfg_wr_en,
  input logic [1:0]            cfg_index,
  input logic [15:0]           cfg_wdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // reset leaves an empty pipe ready for input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipe not empty after reset");

  // end of image is always the last pixel of its byte
  a_last_nested: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("end of image without end of byte");

  // pixels of one byte follow back to back with rising x
  a_item_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser[0] |=>
      m_axis_tvalid && m_axis_tdata[15:0] == $past(m_axis_tdata[15:0]) + 16'd1)
    else $error("gap or x jump inside one byte");

endmodule

bind bmp_pixel_row_unpacker bmp_checker u_bmp_checker (.*);
